@@ rtl/core/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Request, response and entry layouts, status codes and build defaults.
// ----------------------------------------------------------------------------
package skt_pkg;

    // build defaults
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int LIMIT_W         = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // cells merged per group in the first level of the gather tree
    localparam int GROUP_SIZE = 8;

    // request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // response status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_KEY  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DUP       = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [63:0] key;
        logic [63:0] ref_value;
        logic [31:0] auth_bits;
        logic [31:0] cap_bits;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [63:0] entry_ref;
        logic [31:0] entry_auth_req;
        logic [31:0] entry_cap_req;
        logic        requirements_met;
    } t_rsp;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] refv;
        logic [31:0] auth;
        logic [31:0] cap;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic cmp_en;
        logic shift_en;
    } t_cell_ctl;

endpackage

@@ rtl/core/sorted_key_table_with_mask_check.sv @@
// An insert response passes the cell compare flags and the output register;
//   a lookup also passes both registers of the two-level gather tree.
// One request at a time: a new one is taken only when the sequencer is idle.
// A full output register can hold the next response back until it is taken.
// Reset (synchronous, active low) empties the table and sets the limit to 64;
//   no clearing pass, the table is ready in the cycle after reset.
// ----------------------------------------------------------------------------
// sorted_key_table_with_mask_check: sorted key table with mask check
// A row of cells keeps entries in ascending key order; inserts shift the
// upper part of the row by one slot, lookups gather the matching entry.
// ----------------------------------------------------------------------------
module sorted_key_table_with_mask_check #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  skt_pkg::t_req                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output skt_pkg::t_rsp                o_out_data,
    input  logic                         i_cfg_we,
    input  logic [skt_pkg::LIMIT_W-1:0]  i_cfg_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LW    = (CNT_W > skt_pkg::LIMIT_W) ? CNT_W : skt_pkg::LIMIT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_LK1  = 3'd2;
    localparam logic [2:0] S_LK2  = 3'd3;
    localparam logic [2:0] S_LKD  = 3'd4;

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    skt_pkg::t_req               r_req;
    logic [CNT_W-1:0]            r_count;
    logic [skt_pkg::LIMIT_W-1:0] r_limit;
    logic                        r_out_valid;
    skt_pkg::t_rsp               r_out;
    skt_pkg::t_rsp               n_out;

    logic                        w_accept;
    logic                        w_slot_free;
    logic                        w_emit;
    logic                        w_commit;
    logic                        w_full;
    logic                        w_dup;
    skt_pkg::t_cell_ctl          w_ctl;
    skt_pkg::t_entry             w_new;
    skt_pkg::t_entry             w_entry [TABLE_DEPTH];
    skt_pkg::t_entry             w_sel   [TABLE_DEPTH];
    logic [skt_pkg::ENTRY_W-1:0] w_sel_v [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]      w_ge;
    logic [TABLE_DEPTH-1:0]      w_hit;
    logic [skt_pkg::ENTRY_W-1:0] w_sum_v;
    skt_pkg::t_entry             w_sum;
    logic                        w_found;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= skt_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
    end

    // cell row
    assign w_new.key  = r_req.key;
    assign w_new.refv = r_req.ref_value;
    assign w_new.auth = r_req.auth_bits;
    assign w_new.cap  = r_req.cap_bits;

    assign w_ctl.cmp_en   = w_accept;
    assign w_ctl.shift_en = w_commit;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        skt_pkg::t_entry w_prev;
        logic            w_prev_ge;
        if (i == 0) begin : g_first
            assign w_prev    = '0;
            assign w_prev_ge = 1'b0;
        end else begin : g_link
            assign w_prev    = w_entry[i-1];
            assign w_prev_ge = w_ge[i-1];
        end
        skt_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_key     (i_in_data.key),
            .i_count   (r_count),
            .i_new     (w_new),
            .i_prev    (w_prev),
            .i_prev_ge (w_prev_ge),
            .o_entry   (w_entry[i]),
            .o_ge      (w_ge[i]),
            .o_hit     (w_hit[i]),
            .o_sel     (w_sel[i])
        );
        assign w_sel_v[i] = w_sel[i];
    end

    // lookup gather
    skt_gather #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_gather (
        .i_clk (i_clk),
        .i_sel (w_sel_v),
        .o_sum (w_sum_v)
    );

    assign w_sum   = w_sum_v;
    // stored keys are never zero, so a non-zero gathered key means a hit
    assign w_found = (w_sum.key != 64'd0);

    // insert checks
    assign w_full = (LW'(r_count) >= LW'(r_limit)) || (LW'(r_count) >= LW'(TABLE_DEPTH));
    assign w_dup  = |w_hit;

    assign w_emit   = w_slot_free && ((r_state == S_INS) || (r_state == S_LKD));
    assign w_commit = w_slot_free && (r_state == S_INS) && (r_req.key != 64'd0)
                      && !w_full && !w_dup;

    // response build
    always_comb begin
        n_out = '0;
        if (r_state == S_INS) begin
            if (r_req.key == 64'd0) begin
                n_out.status = skt_pkg::ST_ZERO_KEY;
            end else if (w_full) begin
                n_out.status = skt_pkg::ST_FULL;
            end else if (w_dup) begin
                n_out.status = skt_pkg::ST_DUP;
            end else begin
                n_out.status = skt_pkg::ST_OK;
            end
        end else if (w_found) begin
            n_out.status           = skt_pkg::ST_OK;
            n_out.found            = 1'b1;
            n_out.entry_ref        = w_sum.refv;
            n_out.entry_auth_req   = w_sum.auth;
            n_out.entry_cap_req    = w_sum.cap;
            n_out.requirements_met = ((r_req.auth_bits & w_sum.auth) == w_sum.auth)
                                     && ((r_req.cap_bits & w_sum.cap) == w_sum.cap);
        end else begin
            n_out.status = skt_pkg::ST_NOT_FOUND;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_data.mode == skt_pkg::MODE_INSERT) ? S_INS : S_LK1;
                end
            end
            S_INS: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LK1: begin
                n_state = S_LK2;
            end
            S_LK2: begin
                n_state = S_LKD;
            end
            S_LKD: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // entry count stays within the built depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_count) <= LW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // a committed insert grows the table by exactly one
    a_commit_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert commit did not advance count");

    // sorted unique keys give at most one matching cell
    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell matched the key");

    // a found lookup always reports ok
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found) |-> (o_out_data.status == skt_pkg::ST_OK))
        else $error("found response without ok status");
`endif

endmodule

@@ rtl/core/skt_cell.sv @@
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted table
// Holds one entry, compares it with the request key and, on an insert
// commit, takes the new entry or its lower neighbor's, or keeps its own.
// ----------------------------------------------------------------------------
module skt_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  skt_pkg::t_cell_ctl  i_ctl,
    input  logic [63:0]         i_key,
    input  logic [CNT_W-1:0]    i_count,
    input  skt_pkg::t_entry     i_new,
    input  skt_pkg::t_entry     i_prev,
    input  logic                i_prev_ge,
    output skt_pkg::t_entry     o_entry,
    output logic                o_ge,
    output logic                o_hit,
    output skt_pkg::t_entry     o_sel
);

    skt_pkg::t_entry r_entry;
    logic            r_ge;
    logic            r_hit;
    logic            w_valid;
    logic            w_reach;

    // slot holds a live entry / slot is at or below the first free slot
    assign w_valid = i_count > CNT_W'(IDX);
    assign w_reach = i_count >= CNT_W'(IDX);

    // compare flags, taken when a request is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ge  <= 1'b0;
            r_hit <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_ge  <= !w_valid || (r_entry.key > i_key);
            r_hit <= w_valid && (r_entry.key == i_key);
        end
    end

    // insert: first empty or larger-key slot takes the new entry, later ones shift up
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            if (r_ge && !i_prev_ge) begin
                r_entry <= i_new;
            end else if (i_prev_ge && w_reach) begin
                r_entry <= i_prev;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_ge    = r_ge;
    assign o_hit   = r_hit;
    assign o_sel   = r_hit ? r_entry : '0;

endmodule

@@ rtl/core/skt_gather.sv @@
// ----------------------------------------------------------------------------
// skt_gather: registered or-tree over the cell outputs
// At most one cell drives a non-zero entry; two register levels merge
// the cells in groups and then the groups into one entry.
// ----------------------------------------------------------------------------
module skt_gather #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic [skt_pkg::ENTRY_W-1:0]  i_sel [TABLE_DEPTH],
    output logic [skt_pkg::ENTRY_W-1:0]  o_sum
);

    localparam int GS = skt_pkg::GROUP_SIZE;
    localparam int NG = (TABLE_DEPTH + GS - 1) / GS;

    logic [skt_pkg::ENTRY_W-1:0] w_pad [NG*GS];
    logic [skt_pkg::ENTRY_W-1:0] n_grp [NG];
    logic [skt_pkg::ENTRY_W-1:0] r_grp [NG];
    logic [skt_pkg::ENTRY_W-1:0] n_sum;
    logic [skt_pkg::ENTRY_W-1:0] r_sum;

    // pad the last group with zeros
    for (genvar k = 0; k < NG*GS; k++) begin : g_pad
        if (k < TABLE_DEPTH) begin : g_live
            assign w_pad[k] = i_sel[k];
        end else begin : g_zero
            assign w_pad[k] = '0;
        end
    end

    // first level: one group per register
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GS; j++) begin
                n_grp[g] = n_grp[g] | w_pad[g*GS + j];
            end
        end
    end

    // second level: merge the groups
    always_comb begin
        n_sum = '0;
        for (int g = 0; g < NG; g++) begin
            n_sum = n_sum | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

@@ tb/skt_table_checker.sv @@
// ----------------------------------------------------------------------------
// skt_table_checker: scoreboard for the sorted key table
// Watches the request, response and limit ports, keeps its own copy of the
// table and the limit, predicts one response per accepted request and
// compares each accepted response, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module skt_table_checker
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_req               i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_rsp               i_out_data,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_outstanding,
    output int                 o_insert_ok_count,
    output int                 o_insert_refused_count,
    output int                 o_lookup_hit_count,
    output int                 o_lookup_met_count
);

    // shadow copy of the table
    logic [63:0]        shadow_key  [TABLE_DEPTH];
    logic [63:0]        shadow_ref  [TABLE_DEPTH];
    logic [31:0]        shadow_auth [TABLE_DEPTH];
    logic [31:0]        shadow_cap  [TABLE_DEPTH];
    int                 shadow_count;
    logic [LIMIT_W-1:0] shadow_limit;

    t_rsp rsp_expected_q[$];
    int   fail_total;
    int   outstanding_q;
    int   insert_ok;
    int   insert_refused;
    int   lookup_hit;
    int   lookup_met;

    assign o_fail_count           = fail_total;
    assign o_outstanding          = outstanding_q;
    assign o_insert_ok_count      = insert_ok;
    assign o_insert_refused_count = insert_refused;
    assign o_lookup_hit_count     = lookup_hit;
    assign o_lookup_met_count     = lookup_met;

    // apply one request to the shadow table and return its response
    function automatic t_rsp apply_table_request(t_req rq);
        t_rsp rsp;
        int   eff_limit;
        int   pos;
        int   i;
        bit   hit;
        bit   done;
        rsp       = '0;
        eff_limit = (int'(shadow_limit) < TABLE_DEPTH) ? int'(shadow_limit) : TABLE_DEPTH;
        // first slot whose key is not below the request key
        pos  = 0;
        hit  = 1'b0;
        done = 1'b0;
        while (!done && pos < shadow_count) begin
            if (shadow_key[pos] == rq.key) begin
                hit  = 1'b1;
                done = 1'b1;
            end else if (shadow_key[pos] > rq.key) begin
                done = 1'b1;
            end else begin
                pos++;
            end
        end
        if (rq.mode == MODE_INSERT) begin
            if (rq.key == '0) begin
                rsp.status = ST_ZERO_KEY;
            end else if (shadow_count >= eff_limit) begin
                rsp.status = ST_FULL;
            end else if (hit) begin
                rsp.status = ST_DUP;
            end else begin
                for (i = shadow_count; i > pos; i--) begin
                    shadow_key[i]  = shadow_key[i-1];
                    shadow_ref[i]  = shadow_ref[i-1];
                    shadow_auth[i] = shadow_auth[i-1];
                    shadow_cap[i]  = shadow_cap[i-1];
                end
                shadow_key[pos]  = rq.key;
                shadow_ref[pos]  = rq.ref_value;
                shadow_auth[pos] = rq.auth_bits;
                shadow_cap[pos]  = rq.cap_bits;
                shadow_count++;
                rsp.status = ST_OK;
            end
            if (rsp.status == ST_OK) insert_ok++;
            else insert_refused++;
        end else begin
            if (hit && rq.key != '0) begin
                rsp.status           = ST_OK;
                rsp.found            = 1'b1;
                rsp.entry_ref        = shadow_ref[pos];
                rsp.entry_auth_req   = shadow_auth[pos];
                rsp.entry_cap_req    = shadow_cap[pos];
                rsp.requirements_met = ((rq.auth_bits & shadow_auth[pos]) == shadow_auth[pos])
                                    && ((rq.cap_bits & shadow_cap[pos]) == shadow_cap[pos]);
                lookup_hit++;
                if (rsp.requirements_met) lookup_met++;
            end else begin
                rsp.status = ST_NOT_FOUND;
            end
        end
        return rsp;
    endfunction

    // one field compare
    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $error("response field %s: expected %h, got %h", name, exp_val, act_val);
            fail_total++;
        end
    endtask

    // watch the ports on every rising edge
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            shadow_count   = 0;
            shadow_limit   = LIMIT_RESET;
            fail_total     = 0;
            insert_ok      = 0;
            insert_refused = 0;
            lookup_hit     = 0;
            lookup_met     = 0;
            rsp_expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (rsp_expected_q.size() == 0) begin
                    $error("response with no request waiting: %h", i_out_data);
                    fail_total++;
                end else begin
                    exp_rsp = rsp_expected_q.pop_front();
                    check_field("status", 64'(exp_rsp.status), 64'(i_out_data.status));
                    check_field("found", 64'(exp_rsp.found), 64'(i_out_data.found));
                    check_field("entry_ref", exp_rsp.entry_ref, i_out_data.entry_ref);
                    check_field("entry_auth_req", 64'(exp_rsp.entry_auth_req),
                                64'(i_out_data.entry_auth_req));
                    check_field("entry_cap_req", 64'(exp_rsp.entry_cap_req),
                                64'(i_out_data.entry_cap_req));
                    check_field("requirements_met", 64'(exp_rsp.requirements_met),
                                64'(i_out_data.requirements_met));
                end
            end
            if (i_in_valid && i_in_ready) begin
                rsp_expected_q.push_back(apply_table_request(i_in_data));
            end
            if (i_cfg_we) begin
                shadow_limit = i_cfg_data;
            end
        end
        outstanding_q <= rsp_expected_q.size();
    end

endmodule

@@ tb/sorted_key_table_with_mask_check_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_with_mask_check_tb: testbench for the sorted key table
// Drives a short directed run over refusals, extremes and mask checks, then
// random phases over several limit settings with random idling on both sides in
// phases 0-3, a long receiver hold-off and drain pauses; the checker scores it.
// ----------------------------------------------------------------------------
module sorted_key_table_with_mask_check_tb;
    import skt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int POOL_SIZE     = 96;
    localparam int PHASE_ITEMS   = 100;
    localparam int NUM_PHASES    = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [63:0] KEY_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_MSB = 64'h8000_0000_0000_0000;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    t_req               in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_rsp               out_data;
    logic               cfg_we = 1'b0;
    logic [LIMIT_W-1:0] cfg_data = '0;

    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic rx_hold_toggle = 1'b0;
    logic rx_hold_seen   = 1'b0;
    int   rx_hold_left   = 0;
    int   cycle_cnt      = 0;
    int   req_sent       = 0;

    int fail_count;
    int outstanding;
    int insert_ok_count;
    int insert_refused_count;
    int lookup_hit_count;
    int lookup_met_count;

    logic [63:0] key_pool [POOL_SIZE];
    logic [LIMIT_W-1:0] phase_limit [NUM_PHASES] = '{7'd16, 7'd40, 7'd64, 7'd100, 7'd127, 7'd2};

    sorted_key_table_with_mask_check u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    skt_table_checker u_checker (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (in_valid),
        .i_in_ready             (in_ready),
        .i_in_data              (in_data),
        .i_out_valid            (out_valid),
        .i_out_ready            (out_ready),
        .i_out_data             (out_data),
        .i_cfg_we               (cfg_we),
        .i_cfg_data             (cfg_data),
        .o_fail_count           (fail_count),
        .o_outstanding          (outstanding),
        .o_insert_ok_count      (insert_ok_count),
        .o_insert_refused_count (insert_refused_count),
        .o_lookup_hit_count     (lookup_hit_count),
        .o_lookup_met_count     (lookup_met_count)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("sorted_key_table_with_mask_check_tb failed");
            $finish;
        end
    end

    // response side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        rx_hold_seen <= rx_hold_toggle;
        if (rx_hold_toggle != rx_hold_seen) begin
            rx_hold_left <= HOLD_CYCLES;
            out_ready    <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            out_ready    <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req make_req(logic mode, logic [63:0] key, logic [63:0] refv,
                                      logic [31:0] auth, logic [31:0] cap);
        t_req rq;
        rq.mode      = mode;
        rq.key       = key;
        rq.ref_value = refv;
        rq.auth_bits = auth;
        rq.cap_bits  = cap;
        return rq;
    endfunction

    // random request: mostly pool keys so inserts collide and lookups hit
    function automatic t_req make_random_request();
        t_req rq;
        int   pick;
        rq.mode = $urandom_range(1) ? MODE_LOOKUP : MODE_INSERT;
        pick    = $urandom_range(99);
        if (pick < 4) rq.key = '0;
        else if (pick < 84) rq.key = key_pool[$urandom_range(POOL_SIZE-1)];
        else rq.key = rand64();
        case ($urandom_range(3))
            0: rq.ref_value = '0;
            1: rq.ref_value = KEY_MAX;
            default: rq.ref_value = rand64();
        endcase
        if (rq.mode == MODE_INSERT) begin
            // mostly sparse requirement masks so held masks can cover them
            case ($urandom_range(2))
                0: begin
                    rq.auth_bits = '0;
                    rq.cap_bits  = $urandom & $urandom & $urandom;
                end
                1: begin
                    rq.auth_bits = $urandom & $urandom & $urandom;
                    rq.cap_bits  = $urandom & $urandom & $urandom;
                end
                default: begin
                    rq.auth_bits = $urandom;
                    rq.cap_bits  = $urandom;
                end
            endcase
        end else begin
            case ($urandom_range(2))
                0: begin
                    rq.auth_bits = '1;
                    rq.cap_bits  = '1;
                end
                1: begin
                    rq.auth_bits = $urandom | $urandom | $urandom;
                    rq.cap_bits  = $urandom | $urandom | $urandom;
                end
                default: begin
                    rq.auth_bits = $urandom;
                    rq.cap_bits  = $urandom;
                end
            endcase
        end
        return rq;
    endfunction

    // offer one request and hold it until accepted
    task automatic send_request(input t_req rq);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= rq;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        req_sent++;
    endtask

    // stop offering and wait until every response is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        key_pool[0] = 64'd1;
        key_pool[1] = KEY_MAX;
        key_pool[2] = KEY_MSB;
        key_pool[3] = 64'h7FFF_FFFF_FFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = rand64();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero limit: every insert is full, zero key refused first
        write_limit(7'd0);
        send_request(make_req(MODE_INSERT, 64'd5, 64'd7, 32'h1, 32'h1));
        send_request(make_req(MODE_INSERT, 64'd0, 64'd7, 32'h1, 32'h1));
        wait_drained();

        // small table: fill, duplicate, full, then lookups
        write_limit(7'd3);
        send_request(make_req(MODE_INSERT, KEY_MAX, KEY_MAX, '1, '1));
        send_request(make_req(MODE_INSERT, 64'd1, 64'd0, 32'h0000_00F0, 32'h0000_0001));
        send_request(make_req(MODE_INSERT, 64'd1, 64'd9, 32'h0, 32'h0));
        send_request(make_req(MODE_INSERT, KEY_MSB, rand64(), 32'h0, 32'h0));
        send_request(make_req(MODE_INSERT, 64'h42, 64'd3, 32'h0, 32'h0));
        send_request(make_req(MODE_INSERT, 64'd0, 64'd3, 32'h0, 32'h0));
        send_request(make_req(MODE_LOOKUP, 64'd0, KEY_MAX, '1, '1));
        send_request(make_req(MODE_LOOKUP, KEY_MAX, 64'd0, '1, '1));
        send_request(make_req(MODE_LOOKUP, KEY_MAX, 64'd0, '1, 32'h7FFF_FFFF));
        send_request(make_req(MODE_LOOKUP, 64'd1, KEY_MAX, 32'h0, 32'h0));
        send_request(make_req(MODE_LOOKUP, 64'd1, 64'd0, 32'h0000_00F0, 32'h0000_0001));
        send_request(make_req(MODE_LOOKUP, KEY_MSB, 64'd0, 32'h0, 32'h0));
        send_request(make_req(MODE_LOOKUP, 64'd2, 64'd0, '1, '1));
        send_request(make_req(MODE_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, '1, '1));
        wait_drained();

        // random phases over several limits, idling schedule by phase pairs
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph / 2)
                0: begin
                    tx_idle_pct  = 18;
                    rx_stall_pct = 56;
                end
                1: begin
                    tx_idle_pct  = 56;
                    rx_stall_pct = 18;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            write_limit(phase_limit[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while requests keep coming
                if ((ph == 0 || ph == 4) && n == 20) rx_hold_toggle <= ~rx_hold_toggle;
                // sender pause until the table has answered everything
                if (ph == 3 && n == 50) wait_drained();
                send_request(make_random_request());
            end
            wait_drained();
        end

        repeat (12) @(posedge i_clk);
        $display("covered %0d requests over %0d limit settings: %0d inserts placed, %0d refused",
                 req_sent, NUM_PHASES + 2, insert_ok_count, insert_refused_count);
        $display("lookups found %0d entries, %0d of them with requirements met",
                 lookup_hit_count, lookup_met_count);
        if (fail_count == 0) begin
            $display("sorted_key_table_with_mask_check_tb passed");
        end else begin
            $display("sorted_key_table_with_mask_check_tb failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/skt_pkg.sv
rtl/core/skt_cell.sv
rtl/core/skt_gather.sv
rtl/core/sorted_key_table_with_mask_check.sv
tb/skt_table_checker.sv
tb/sorted_key_table_with_mask_check_tb.sv
